[sv/fcsg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcsg_pkg
// shared widths, command record and walker state type for the span generator
// ----------------------------------------------------------------------------
package fcsg_pkg;

  localparam int unsigned COL_W    = 7;
  localparam int unsigned ROW_W    = 6;
  localparam int unsigned RAD_W    = 5;
  localparam int unsigned COLOUR_W = 24;
  localparam int unsigned SPAN_W   = 8;
  localparam int unsigned WALK_W   = 7;
  localparam int unsigned ERR_W    = 10;

  // classified circle command as held in the queue
  typedef struct packed {
    logic [COL_W-1:0]        center_col;
    logic [ROW_W-1:0]        center_row;
    logic [RAD_W-1:0]        radius;
    logic signed [ERR_W-1:0] err_init;
    logic [COLOUR_W-1:0]     colour;
  } cmd_t;

  // queue to walker handshake
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAIN_P,
    ST_MAIN_N,
    ST_CAP_P,
    ST_CAP_N
  } walk_st_e;

endpackage
`default_nettype wire

[sv/fcsg_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcsg channel interfaces
// circle command channel and span result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface fcsg_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [fcsg_pkg::COL_W-1:0]    center_col;
  logic [fcsg_pkg::ROW_W-1:0]    center_row;
  logic [fcsg_pkg::RAD_W-1:0]    circle_radius;
  logic [fcsg_pkg::COLOUR_W-1:0] fill_colour;

  modport source (output valid, center_col, center_row, circle_radius, fill_colour,
                  input ready);
  modport sink   (input valid, center_col, center_row, circle_radius, fill_colour,
                  output ready);
endinterface

interface fcsg_span_if;
  logic                              valid;
  logic                              ready;
  logic signed [fcsg_pkg::SPAN_W-1:0] span_start_col;
  logic signed [fcsg_pkg::SPAN_W-1:0] span_end_col;
  logic signed [fcsg_pkg::SPAN_W-1:0] span_row;
  logic [fcsg_pkg::COLOUR_W-1:0]     span_colour;
  logic                              last_span;

  modport source (output valid, span_start_col, span_end_col, span_row, span_colour,
                  last_span, input ready);
  modport sink   (input valid, span_start_col, span_end_col, span_row, span_colour,
                  last_span, output ready);
endinterface
`default_nettype wire

[sv/fcsg_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcsg_front
// takes circle requests, saturates the radius, seeds the decision term and
// holds them in a two-entry queue for the walker
// ----------------------------------------------------------------------------
module fcsg_front #(
  parameter int unsigned MAX_RADIUS = 31
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  fcsg_cmd_if.sink              cmd_i,
  output fcsg_pkg::cmd_req_t    req_o,
  input  wire                   pop_i
);

  fcsg_pkg::cmd_t entry_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;
  logic           push;
  logic           pop;

  logic [fcsg_pkg::RAD_W-1:0] radius_sat;
  fcsg_pkg::cmd_t             cmd_new;

  assign cmd_i.ready = (count_q != 2'd2);
  assign push        = cmd_i.valid && cmd_i.ready;
  assign pop         = pop_i && (count_q != 2'd0);

  // clamp radius to the configured maximum
  assign radius_sat = (int'(cmd_i.circle_radius) > int'(MAX_RADIUS))
                      ? fcsg_pkg::RAD_W'(MAX_RADIUS) : cmd_i.circle_radius;

  always_comb begin
    cmd_new.center_col = cmd_i.center_col;
    cmd_new.center_row = cmd_i.center_row;
    cmd_new.radius     = radius_sat;
    cmd_new.err_init   = fcsg_pkg::ERR_W'(1)
                         - $signed({{(fcsg_pkg::ERR_W-fcsg_pkg::RAD_W){1'b0}}, radius_sat});
    cmd_new.colour     = cmd_i.fill_colour;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  assign req_o.valid = (count_q != 2'd0);
  assign req_o.cmd   = entry_q[rd_ptr_q];

endmodule
`default_nettype wire

[sv/fcsg_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcsg_back
// midpoint circle walker, one span per step into a registered output stage
// ----------------------------------------------------------------------------
module fcsg_back (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  fcsg_pkg::cmd_req_t    req_i,
  output logic                  pop_o,
  fcsg_span_if.source           span_o
);

  localparam int unsigned SW = fcsg_pkg::SPAN_W;
  localparam int unsigned WW = fcsg_pkg::WALK_W;
  localparam int unsigned EW = fcsg_pkg::ERR_W;

  fcsg_pkg::walk_st_e st_q, st_d;

  logic signed [WW-1:0] x_q, x_d, y_q, y_d;
  logic signed [EW-1:0] err_q, err_d;
  logic [fcsg_pkg::COL_W-1:0]    cc_q, cc_d;
  logic [fcsg_pkg::ROW_W-1:0]    cr_q, cr_d;
  logic [fcsg_pkg::COLOUR_W-1:0] colour_q, colour_d;

  logic                 out_valid_q;
  logic signed [SW-1:0] out_start_q, out_end_q, out_row_q;
  logic [fcsg_pkg::COLOUR_W-1:0] out_colour_q;
  logic                 out_last_q;

  logic signed [SW-1:0] start_c, end_c, row_c;
  logic                 last_c;
  logic                 step;

  logic signed [WW-1:0] y1, xm;
  logic signed [EW-1:0] err_neg, err_main, err_cap;
  logic signed [SW-1:0] cc8, cr8, x8, y8;

  // 2 * (y - xm + 1), sign extended to the decision width
  function automatic logic signed [EW-1:0] err_step(input logic signed [WW-1:0] y,
                                                    input logic signed [WW-1:0] xn);
    logic signed [WW:0] d;
    d = {y[WW-1], y} - {xn[WW-1], xn} + (WW+1)'(1);
    return {{(EW-WW-2){d[WW]}}, d, 1'b0};
  endfunction

  assign step     = (st_q != fcsg_pkg::ST_IDLE) && (!out_valid_q || span_o.ready);
  assign y1       = y_q + WW'(1);
  assign xm       = x_q - WW'(1);
  assign err_neg  = err_q + $signed({{(EW-WW-1){1'b0}}, y1, 1'b1});
  assign err_main = err_q + err_step(y1, xm);
  assign err_cap  = err_q + err_step(y_q, xm);

  // next state and walk registers
  always_comb begin
    st_d     = st_q;
    x_d      = x_q;
    y_d      = y_q;
    err_d    = err_q;
    cc_d     = cc_q;
    cr_d     = cr_q;
    colour_d = colour_q;
    pop_o    = 1'b0;
    case (st_q)
      fcsg_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          pop_o    = 1'b1;
          x_d      = $signed({{(WW-fcsg_pkg::RAD_W){1'b0}}, req_i.cmd.radius});
          y_d      = '0;
          err_d    = req_i.cmd.err_init;
          cc_d     = req_i.cmd.center_col;
          cr_d     = req_i.cmd.center_row;
          colour_d = req_i.cmd.colour;
          st_d     = fcsg_pkg::ST_MAIN_P;
        end
      end
      fcsg_pkg::ST_MAIN_P, fcsg_pkg::ST_MAIN_N: begin
        if (step) begin
          if (st_q == fcsg_pkg::ST_MAIN_P && y_q != '0) begin
            st_d = fcsg_pkg::ST_MAIN_N;
          end else begin
            y_d = y1;
            if (err_q < 0) begin
              err_d = err_neg;
              st_d  = (x_q >= y1) ? fcsg_pkg::ST_MAIN_P : fcsg_pkg::ST_IDLE;
            end else if (x_q >= y1) begin
              st_d = fcsg_pkg::ST_CAP_P;
            end else begin
              x_d   = xm;
              err_d = err_main;
              st_d  = (xm >= y1) ? fcsg_pkg::ST_MAIN_P : fcsg_pkg::ST_IDLE;
            end
          end
        end
      end
      fcsg_pkg::ST_CAP_P: begin
        if (step) st_d = fcsg_pkg::ST_CAP_N;
      end
      fcsg_pkg::ST_CAP_N: begin
        if (step) begin
          x_d   = xm;
          err_d = err_cap;
          st_d  = (xm >= y_q) ? fcsg_pkg::ST_MAIN_P : fcsg_pkg::ST_IDLE;
        end
      end
      default: st_d = fcsg_pkg::ST_IDLE;
    endcase
  end

  assign cc8 = $signed({1'b0, cc_q});
  assign cr8 = $signed({2'b00, cr_q});
  assign x8  = {x_q[WW-1], x_q};
  assign y8  = {y_q[WW-1], y_q};

  // span produced in the current state
  always_comb begin
    start_c = cc8 - x8;
    end_c   = cc8 + x8;
    row_c   = cr8 + y8;
    case (st_q)
      fcsg_pkg::ST_MAIN_N: row_c = cr8 - y8;
      fcsg_pkg::ST_CAP_P: begin
        start_c = cc8 - y8 + SW'(1);
        end_c   = cc8 + y8 - SW'(1);
        row_c   = cr8 + x8;
      end
      fcsg_pkg::ST_CAP_N: begin
        start_c = cc8 - y8 + SW'(1);
        end_c   = cc8 + y8 - SW'(1);
        row_c   = cr8 - x8;
      end
      default: row_c = cr8 + y8;
    endcase
    last_c = (st_q != fcsg_pkg::ST_IDLE) && (st_d == fcsg_pkg::ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= fcsg_pkg::ST_IDLE;
      x_q      <= '0;
      y_q      <= '0;
      err_q    <= '0;
      cc_q     <= '0;
      cr_q     <= '0;
      colour_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      x_q      <= x_d;
      y_q      <= y_d;
      err_q    <= err_d;
      cc_q     <= cc_d;
      cr_q     <= cr_d;
      colour_q <= colour_d;
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (span_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_start_q  <= start_c;
      out_end_q    <= end_c;
      out_row_q    <= row_c;
      out_colour_q <= colour_q;
      out_last_q   <= last_c;
    end
  end

  assign span_o.valid          = out_valid_q;
  assign span_o.span_start_col = out_start_q;
  assign span_o.span_end_col   = out_end_q;
  assign span_o.span_row       = out_row_q;
  assign span_o.span_colour    = out_colour_q;
  assign span_o.last_span      = out_last_q;

endmodule
`default_nettype wire

[sv/filled_circle_span_generator_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// filled_circle_span_generator_core
// filled circle rasteriser: one circle request in, its horizontal spans out
// ----------------------------------------------------------------------------
// usage
//   cmd_i  : circle requests (centre column/row, radius, colour), valid/ready
//   span_o : horizontal spans (start col, end col, row, colour, last mark)
//   a request is taken whenever the two-entry request queue has room, so up
//   to two circles can wait while a third is being walked
//   when the walker is free, the first span of a circle passes through the
//   queue entry, the walker's idle load and the output register to span_o
//   throughput: one span per cycle from the midpoint walker while span_o is
//   ready; each circle is loaded in idle after the last span of the one
//   before, and a radius r circle gives 2r+1 spans from the single span step
//   spans leave through an output register; when the receiver holds ready
//   low the walker stops on the pending span and the queue keeps filling
//   reset clears the queue, returns the walker to idle and drops any span
//   that was waiting; no clearing pass is needed
// ----------------------------------------------------------------------------
module filled_circle_span_generator_core #(
  parameter int unsigned MAX_RADIUS = 31
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  fcsg_cmd_if.sink     cmd_i,
  fcsg_span_if.source  span_o
);

  // queue head offered to the walker
  fcsg_pkg::cmd_req_t req;
  // walker takes the queue head
  logic               pop;

  // front: accept, saturate radius, seed decision term, queue
  fcsg_front #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_i),
    .req_o  (req),
    .pop_i  (pop)
  );

  // back: midpoint walk, main spans interleaved with cap spans, registered output
  fcsg_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .pop_o  (pop),
    .span_o (span_o)
  );

endmodule
`default_nettype wire

[sv/fcsg_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcsg_checker
// port-level checks on the span generator, bound to the top level
// ----------------------------------------------------------------------------
module fcsg_checker (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire                                cmd_valid_i,
  input wire                                cmd_ready_i,
  input wire                                span_valid_i,
  input wire                                span_ready_i,
  input wire signed [fcsg_pkg::SPAN_W-1:0]  span_start_col_i,
  input wire signed [fcsg_pkg::SPAN_W-1:0]  span_end_col_i,
  input wire signed [fcsg_pkg::SPAN_W-1:0]  span_row_i,
  input wire [fcsg_pkg::COLOUR_W-1:0]       span_colour_i,
  input wire                                last_span_i
);

  logic                          cmd_acc, span_acc;
  logic [2:0]                    open_q;
  logic                          prev_last_q;
  logic [fcsg_pkg::COLOUR_W-1:0] prev_colour_q;

  assign cmd_acc  = cmd_valid_i && cmd_ready_i;
  assign span_acc = span_valid_i && span_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q        <= '0;
      prev_last_q   <= 1'b1;
      prev_colour_q <= '0;
    end else begin
      case ({cmd_acc, span_acc && last_span_i})
        2'b10:   open_q <= open_q + 3'd1;
        2'b01:   open_q <= open_q - 3'd1;
        default: open_q <= open_q;
      endcase
      if (span_acc) begin
        prev_last_q   <= last_span_i;
        prev_colour_q <= span_colour_i;
      end
    end
  end

  a_span_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_valid_i && !span_ready_i |=> span_valid_i && $stable(span_row_i)
      && $stable(span_start_col_i) && $stable(last_span_i))
    else $error("stalled span changed");

  a_span_needs_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_valid_i |-> open_q != 3'd0)
    else $error("span without an open circle request");

  a_colour_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_acc && !prev_last_q |-> span_colour_i == prev_colour_q)
    else $error("colour changed within one circle");

  a_span_symmetric: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_valid_i |-> span_start_col_i[0] == span_end_col_i[0])
    else $error("span not symmetric about the centre");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_valid_i |-> span_row_i >= -8'sd31 && span_row_i <= 8'sd94)
    else $error("span row out of range");

endmodule

bind filled_circle_span_generator_core fcsg_checker u_fcsg_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .cmd_valid_i      (cmd_i.valid),
  .cmd_ready_i      (cmd_i.ready),
  .span_valid_i     (span_o.valid),
  .span_ready_i     (span_o.ready),
  .span_start_col_i (span_o.span_start_col),
  .span_end_col_i   (span_o.span_end_col),
  .span_row_i       (span_o.span_row),
  .span_colour_i    (span_o.span_colour),
  .last_span_i      (span_o.last_span)
);
`default_nettype wire
